/* src/lfr_pkg.sv */
// Shared constants, types and helpers of the lagged Fibonacci random generator.
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int unsigned DEGREE  = 31;
  localparam int unsigned LAG     = 3;
  localparam int unsigned AW      = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned SEED_W  = 32;

  localparam logic [VALUE_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [VALUE_W-1:0] LCG_ADD = 31'd12345;

  // command codes carried on s_axis_tuser
  localparam logic CMD_NEXT   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef logic [AW-1:0]     pos_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_LCG = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SEED = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // ring position step, wraps at the ring length
  function automatic pos_t pos_bump(input pos_t p);
    pos_bump = (p == pos_t'(DEGREE - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

  // power-on contents of the ring
  function automatic word_t start_word(input pos_t idx);
    case (idx)
      5'd0:    start_word = 32'h5851f42d;
      5'd1:    start_word = 32'hc0b18ccf;
      5'd2:    start_word = 32'hcbb5f646;
      5'd3:    start_word = 32'hc7033129;
      5'd4:    start_word = 32'h30705b04;
      5'd5:    start_word = 32'h20fd5db4;
      5'd6:    start_word = 32'h9a8b7f78;
      5'd7:    start_word = 32'h502959d8;
      5'd8:    start_word = 32'hab894868;
      5'd9:    start_word = 32'h6c0356a7;
      5'd10:   start_word = 32'h88cdb7ff;
      5'd11:   start_word = 32'hb477d43f;
      5'd12:   start_word = 32'h70a3a52b;
      5'd13:   start_word = 32'ha8e4baf1;
      5'd14:   start_word = 32'hfd8341fc;
      5'd15:   start_word = 32'h8ae16fd9;
      5'd16:   start_word = 32'h742d2f7a;
      5'd17:   start_word = 32'h0d1f0796;
      5'd18:   start_word = 32'h76035e09;
      5'd19:   start_word = 32'h40f7702c;
      5'd20:   start_word = 32'h6fa72ca5;
      5'd21:   start_word = 32'haaa84157;
      5'd22:   start_word = 32'h58a0df74;
      5'd23:   start_word = 32'hc74a0364;
      5'd24:   start_word = 32'hae533cc4;
      5'd25:   start_word = 32'h04185faf;
      5'd26:   start_word = 32'h6de3b115;
      5'd27:   start_word = 32'h0cab8628;
      5'd28:   start_word = 32'hf043bfa4;
      5'd29:   start_word = 32'h398150e9;
      5'd30:   start_word = 32'h37521657;
      default: start_word = '0;
    endcase
  endfunction

endpackage

/* src/lfr_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module lfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* src/lfr_alu.sv */
// Shared arithmetic unit: ring word add or one LCG step.
`timescale 1ns / 1ps

module lfr_alu (
  input  lfr_pkg::alu_op_e op_i,
  input  lfr_pkg::word_t   a_i,
  input  lfr_pkg::word_t   b_i,
  output lfr_pkg::word_t   y_o
);
  import lfr_pkg::*;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   lcg;

  // only the low 31 bits of the state matter modulo 2^31
  assign prod = a_i[VALUE_W-1:0] * LCG_MUL;
  assign lcg  = prod[VALUE_W-1:0] + LCG_ADD;

  always_comb begin
    unique case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_LCG: y_o = {1'b0, lcg};
      default: y_o = '0;
    endcase
  end

endmodule

/* src/lagged_fibonacci_random.sv */
// Top level of the additive lagged Fibonacci random generator (31 words, lag 3).
`timescale 1ns / 1ps

// Usage notes
// - Input stream: s_axis_tuser is the command (0 = next value, 1 = reseed),
//   s_axis_tdata the 32-bit seed, ignored on next. One transaction, one result.
// - Output stream: m_axis_tdata[30:0] carries the value; zero after a reseed.
// - Next: the accept cycle reads front and rear words from the two read ports of
//   the ring RAM; in S_ADD, once the output register is free, the shared ALU
//   adds them, writes the sum back and loads the output register.
// - Reseed: the shared ALU runs one LCG step a cycle, 31 steps, one ring write
//   each, then the zero result is loaded.
// - s_axis_tready is high only while the sequencer is idle.
// - Reset: ring contents come from the power-on table through per-word valid
//   bits (cleared at once), positions go to 3 and 0; no clearing pass.
// - Receiver stall: a result waits in the output register; the block still
//   takes the next transaction and parks at its final step until the register
//   is free, so nothing is lost or repeated.
module lagged_fibonacci_random (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lfr_pkg::SEED_W-1:0]    s_axis_tdata,  // [31:0] seed
  input  logic                          s_axis_tuser,  // [0] command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lfr_pkg::WORD_W-1:0]    m_axis_tdata   // [30:0] value, [31] zero
);
  import lfr_pkg::*;

  state_e state_q, state_d;
  pos_t   front_q, front_d;
  pos_t   rear_q, rear_d;
  pos_t   idx_q, idx_d;
  logic [VALUE_W-1:0] lcg_q, lcg_d;
  logic [DEGREE-1:0]  vld_q;

  logic               m_valid_q, m_valid_d;
  logic [VALUE_W-1:0] m_data_q, out_val;
  logic               load_out;

  // ring RAM ports
  logic  we;
  pos_t  waddr;
  word_t wdata, rd_a, rd_b;

  // power-on words for entries never written yet
  logic  vld_a_q, vld_b_q;
  word_t tbl_a_q, tbl_b_q;
  word_t op_a, op_b;

  alu_op_e alu_op;
  word_t   alu_a, alu_y;

  logic accept, out_free;

  lfr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEGREE)
  ) u_ring (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(front_q),
    .raddr_b_i(rear_q),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  lfr_alu u_alu (
    .op_i(alu_op),
    .a_i (alu_a),
    .b_i (op_b),
    .y_o (alu_y)
  );

  assign op_a = vld_a_q ? rd_a : tbl_a_q;
  assign op_b = vld_b_q ? rd_b : tbl_b_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    rear_d   = rear_q;
    idx_d    = idx_q;
    lcg_d    = lcg_q;
    we       = 1'b0;
    waddr    = front_q;
    wdata    = alu_y;
    alu_op   = ALU_ADD;
    alu_a    = op_a;
    load_out = 1'b0;
    out_val  = alu_y[WORD_W-1:1];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == CMD_RESEED) begin
            // the LCG only ever sees the seed modulo 2^31
            lcg_d   = s_axis_tdata[VALUE_W-1:0];
            idx_d   = '0;
            state_d = S_SEED;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (out_free) begin
          we       = 1'b1;
          load_out = 1'b1;
          front_d  = pos_bump(front_q);
          rear_d   = pos_bump(rear_q);
          state_d  = S_IDLE;
        end
      end
      S_SEED: begin
        alu_op = ALU_LCG;
        alu_a  = {1'b0, lcg_q};
        we     = 1'b1;
        waddr  = idx_q;
        // word 0 gets bit 0 forced; the LCG chain itself is untouched
        wdata  = alu_y | WORD_W'(idx_q == '0);
        lcg_d  = alu_y[VALUE_W-1:0];
        idx_d  = pos_t'(idx_q + 1'b1);
        if (idx_q == pos_t'(DEGREE - 1)) begin
          front_d = pos_t'(LAG);
          rear_d  = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          out_val  = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_d = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= pos_t'(LAG);
      rear_q    <= '0;
      idx_q     <= '0;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      rear_q    <= rear_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    lcg_q   <= lcg_d;
    vld_a_q <= vld_q[front_q];
    vld_b_q <= vld_q[rear_q];
    tbl_a_q <= start_word(front_q);
    tbl_b_q <= start_word(rear_q);
    if (load_out) begin
      m_data_q <= out_val;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};

endmodule
